// ----- sv/rpf_pkg.sv -----
package rpf_pkg;

	localparam int SEGMENT_STEPS  = 40;
	localparam int PALETTE_POINTS = 7;
	localparam int LEVEL_FULL     = 255;
	localparam int DIVISOR        = SEGMENT_STEPS * LEVEL_FULL;

	localparam int STEP_W  = 6;
	localparam int POINT_W = 3;
	localparam int LEVEL_W = 8;
	localparam int DUTY_W  = 10;
	localparam int MIX_W   = 14;
	localparam int PROD_W  = MIX_W + DUTY_W;
	localparam int CNT_W   = 4;

	typedef struct packed {
		logic [LEVEL_W-1:0] r;
		logic [LEVEL_W-1:0] g;
		logic [LEVEL_W-1:0] b;
	} color_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_MUL,
		ST_DIV,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic   load;
		state_t op;
	} lane_ctrl_t;

	function automatic color_t palette(input logic [POINT_W-1:0] idx);
		color_t c;
		case (idx)
			3'd0: c = '{r: 8'd220, g: 8'd1,   b: 8'd20};
			3'd1: c = '{r: 8'd220, g: 8'd20,  b: 8'd1};
			3'd2: c = '{r: 8'd110, g: 8'd110, b: 8'd1};
			3'd3: c = '{r: 8'd1,   g: 8'd200, b: 8'd1};
			3'd4: c = '{r: 8'd1,   g: 8'd100, b: 8'd130};
			3'd5: c = '{r: 8'd1,   g: 8'd1,   b: 8'd250};
			3'd6: c = '{r: 8'd100, g: 8'd1,   b: 8'd130};
			default: c = '{r: 8'd0, g: 8'd0, b: 8'd0};
		endcase
		return c;
	endfunction

endpackage

// ----- sv/rgb_palette_fade_interpolator.sv -----
// RGB palette fade interpolator.
// Input channel (in_valid/in_ready, advance): one word per update. advance=1
// steps the fade position, advance=0 only recomputes the duties.
// Output channel (out_valid/out_ready): one word of red/green/blue duties per
// input word, held in an output register until taken.
// Config channel (cfg_valid/cfg_ready, max_brightness): always ready, write
// only while no update is in flight.
// Each channel is computed bit-serially in its own lane: weight-by-level
// accumulation, shift-add scaling, restoring division by 40*255, then a
// load into the output register. A new word is taken only once the previous
// result has been loaded into the output register.
// If the receiver stalls, the finished result waits in the lanes until the
// output register frees, and in_ready stays low meanwhile.
// Reset clears the position to zero, max_brightness to 1023 and drops any
// pending output.
module rgb_palette_fade_interpolator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        advance,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rpf_pkg::DUTY_W-1:0]  red_duty,
	output logic [rpf_pkg::DUTY_W-1:0]  green_duty,
	output logic [rpf_pkg::DUTY_W-1:0]  blue_duty,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rpf_pkg::DUTY_W-1:0]  max_brightness
);

	localparam logic [rpf_pkg::STEP_W-1:0]  LAST_STEP  =
		rpf_pkg::STEP_W'(rpf_pkg::SEGMENT_STEPS - 1);
	localparam logic [rpf_pkg::STEP_W-1:0]  SEG_STEPS  = rpf_pkg::STEP_W'(rpf_pkg::SEGMENT_STEPS);
	localparam logic [rpf_pkg::POINT_W-1:0] LAST_POINT =
		rpf_pkg::POINT_W'(rpf_pkg::PALETTE_POINTS - 1);
	localparam logic [rpf_pkg::CNT_W-1:0]   MIX_LAST   = rpf_pkg::CNT_W'(rpf_pkg::STEP_W - 1);
	localparam logic [rpf_pkg::CNT_W-1:0]   BIT_LAST   = rpf_pkg::CNT_W'(rpf_pkg::DUTY_W - 1);

	rpf_pkg::state_t state_q, state_d;
	logic [rpf_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [rpf_pkg::STEP_W-1:0]  step_q, step_d;
	logic [rpf_pkg::POINT_W-1:0] point_q, point_d, point_nx;
	logic [rpf_pkg::DUTY_W-1:0]  bright_q;
	logic                        out_valid_q;
	logic [rpf_pkg::DUTY_W-1:0]  red_q, green_q, blue_q;
	logic                        accept, out_load;
	rpf_pkg::lane_ctrl_t         lane_ctrl;
	rpf_pkg::color_t             col_a, col_b;
	logic [rpf_pkg::STEP_W-1:0]  ma;
	logic [rpf_pkg::DUTY_W-1:0]  r_lane, g_lane, b_lane;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == rpf_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;

	always_comb begin
		step_d  = step_q;
		point_d = point_q;
		if (accept && advance) begin
			if (step_q == LAST_STEP) begin
				step_d  = '0;
				point_d = (point_q == LAST_POINT) ? '0 : point_q + 1'b1;
			end else begin
				step_d = step_q + 1'b1;
			end
		end
	end

	assign point_nx = (point_q == LAST_POINT) ? '0 : point_q + 1'b1;
	assign col_a    = rpf_pkg::palette(point_q);
	assign col_b    = rpf_pkg::palette(point_nx);
	assign ma       = SEG_STEPS - step_d;

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		out_load       = 1'b0;
		lane_ctrl.load = accept;
		lane_ctrl.op   = state_q;
		case (state_q)
			rpf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = rpf_pkg::ST_MIX;
					cnt_d   = '0;
				end
			end
			rpf_pkg::ST_MIX: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == MIX_LAST) begin
					state_d = rpf_pkg::ST_MUL;
					cnt_d   = '0;
				end
			end
			rpf_pkg::ST_MUL: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == BIT_LAST) begin
					state_d = rpf_pkg::ST_DIV;
					cnt_d   = '0;
				end
			end
			rpf_pkg::ST_DIV: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == BIT_LAST) begin
					state_d = rpf_pkg::ST_HOLD;
					cnt_d   = '0;
				end
			end
			rpf_pkg::ST_HOLD: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = rpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rpf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpf_pkg::ST_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			point_q     <= '0;
			bright_q    <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			step_q  <= step_d;
			point_q <= point_d;
			if (cfg_valid && cfg_ready) begin
				bright_q <= max_brightness;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			red_q   <= r_lane;
			green_q <= g_lane;
			blue_q  <= b_lane;
		end
	end

	rpf_lane u_lane_r (
		.clk(clk), .ctrl(lane_ctrl), .ma(ma), .mb(step_d),
		.level_a(col_a.r), .level_b(col_b.r), .scale(bright_q), .duty(r_lane)
	);

	rpf_lane u_lane_g (
		.clk(clk), .ctrl(lane_ctrl), .ma(ma), .mb(step_d),
		.level_a(col_a.g), .level_b(col_b.g), .scale(bright_q), .duty(g_lane)
	);

	rpf_lane u_lane_b (
		.clk(clk), .ctrl(lane_ctrl), .ma(ma), .mb(step_d),
		.level_a(col_a.b), .level_b(col_b.b), .scale(bright_q), .duty(b_lane)
	);

	assign out_valid  = out_valid_q;
	assign red_duty   = red_q;
	assign green_duty = green_q;
	assign blue_duty  = blue_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < SEG_STEPS)
		else $error("fade step out of range");

	a_point_range: assert property (@(posedge clk) disable iff (!arst_n)
		point_q <= LAST_POINT)
		else $error("palette point out of range");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == rpf_pkg::ST_MIX) && (cnt_q == '0))
		else $error("accepted word did not start the lanes");

	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (red_q <= bright_q) && (green_q <= bright_q) && (blue_q <= bright_q))
		else $error("duty above max brightness");

	a_pos_held: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(step_q) && $stable(point_q))
		else $error("fade position moved without an input word");

endmodule

// ----- sv/rpf_lane.sv -----
module rpf_lane (
	input  logic                          clk,
	input  rpf_pkg::lane_ctrl_t           ctrl,
	input  logic [rpf_pkg::STEP_W-1:0]    ma,
	input  logic [rpf_pkg::STEP_W-1:0]    mb,
	input  logic [rpf_pkg::LEVEL_W-1:0]   level_a,
	input  logic [rpf_pkg::LEVEL_W-1:0]   level_b,
	input  logic [rpf_pkg::DUTY_W-1:0]    scale,
	output logic [rpf_pkg::DUTY_W-1:0]    duty
);

	logic [rpf_pkg::STEP_W-1:0]  ma_q, mb_q;
	logic [rpf_pkg::DUTY_W-1:0]  scale_q;
	logic [rpf_pkg::MIX_W-1:0]   mix_q;
	logic [rpf_pkg::PROD_W-1:0]  p_q;

	logic [rpf_pkg::MIX_W-1:0]   add_a, add_b;
	logic [rpf_pkg::PROD_W-1:0]  add_m;
	logic [rpf_pkg::MIX_W:0]     trial;
	logic                        qbit;
	logic [rpf_pkg::MIX_W-1:0]   rem_next;

	localparam logic [rpf_pkg::MIX_W:0] DIV_C = (rpf_pkg::MIX_W+1)'(rpf_pkg::DIVISOR);

	always_comb begin
		add_a = ma_q[rpf_pkg::STEP_W-1] ? rpf_pkg::MIX_W'(level_a) : '0;
		add_b = mb_q[rpf_pkg::STEP_W-1] ? rpf_pkg::MIX_W'(level_b) : '0;
		add_m = scale_q[rpf_pkg::DUTY_W-1] ? rpf_pkg::PROD_W'(mix_q) : '0;
		// restoring divide: remainder in upper bits, quotient shifts in at the bottom
		trial = {p_q[rpf_pkg::PROD_W-1:rpf_pkg::DUTY_W], p_q[rpf_pkg::DUTY_W-1]};
		qbit  = (trial >= DIV_C);
		rem_next = qbit ? rpf_pkg::MIX_W'(trial - DIV_C) : trial[rpf_pkg::MIX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ma_q    <= ma;
			mb_q    <= mb;
			scale_q <= scale;
			mix_q   <= '0;
			p_q     <= '0;
		end else begin
			case (ctrl.op)
				rpf_pkg::ST_MIX: begin
					mix_q <= {mix_q[rpf_pkg::MIX_W-2:0], 1'b0} + add_a + add_b;
					ma_q  <= {ma_q[rpf_pkg::STEP_W-2:0], 1'b0};
					mb_q  <= {mb_q[rpf_pkg::STEP_W-2:0], 1'b0};
				end
				rpf_pkg::ST_MUL: begin
					p_q     <= {p_q[rpf_pkg::PROD_W-2:0], 1'b0} + add_m;
					scale_q <= {scale_q[rpf_pkg::DUTY_W-2:0], 1'b0};
				end
				rpf_pkg::ST_DIV: begin
					p_q <= {rem_next, p_q[rpf_pkg::DUTY_W-2:0], qbit};
				end
				default: begin
				end
			endcase
		end
	end

	assign duty = p_q[rpf_pkg::DUTY_W-1:0];

endmodule

// ----- verif/tb_top.sv -----
module tb_top;

	localparam int CYCLE_LEN = rpf_pkg::SEGMENT_STEPS * rpf_pkg::PALETTE_POINTS;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [rpf_pkg::DUTY_W-1:0] red;
		logic [rpf_pkg::DUTY_W-1:0] green;
		logic [rpf_pkg::DUTY_W-1:0] blue;
	} duty_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic advance = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [rpf_pkg::DUTY_W-1:0] red_duty;
	logic [rpf_pkg::DUTY_W-1:0] green_duty;
	logic [rpf_pkg::DUTY_W-1:0] blue_duty;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rpf_pkg::DUTY_W-1:0] max_brightness = '0;

	logic [rpf_pkg::LEVEL_W-1:0] lvl_red [0:6] =
		'{8'd220, 8'd220, 8'd110, 8'd1, 8'd1, 8'd1, 8'd100};
	logic [rpf_pkg::LEVEL_W-1:0] lvl_green [0:6] =
		'{8'd1, 8'd20, 8'd110, 8'd200, 8'd100, 8'd1, 8'd1};
	logic [rpf_pkg::LEVEL_W-1:0] lvl_blue [0:6] =
		'{8'd20, 8'd1, 8'd1, 8'd1, 8'd130, 8'd250, 8'd130};

	logic advance_q [$];
	duty_set_t duty_q [$];
	int fade_pos_model = 0;
	logic [rpf_pkg::DUTY_W-1:0] bright_model = 10'd1023;
	logic in_taken = 1'b0;
	logic idle_on = 1'b1;
	int err_count = 0;
	int cycle_cnt = 0;

	rgb_palette_fade_interpolator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.advance(advance),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red_duty(red_duty),
		.green_duty(green_duty),
		.blue_duty(blue_duty),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_brightness(max_brightness)
	);

	always #5 clk = ~clk;

	function automatic logic [rpf_pkg::DUTY_W-1:0] scale_level(input int wa, input int la,
			input int wb, input int lb, input int bright);
		int mix;
		mix = wa * la + wb * lb;
		return rpf_pkg::DUTY_W'((mix * bright) / rpf_pkg::DIVISOR);
	endfunction

	function automatic duty_set_t fade_duties(input int pos, input int bright);
		int pa, pb, mb, ma;
		duty_set_t d;
		pa = pos / rpf_pkg::SEGMENT_STEPS;
		pb = (pa + 1) % rpf_pkg::PALETTE_POINTS;
		mb = pos % rpf_pkg::SEGMENT_STEPS;
		ma = rpf_pkg::SEGMENT_STEPS - mb;
		d.red = scale_level(ma, lvl_red[pa], mb, lvl_red[pb], bright);
		d.green = scale_level(ma, lvl_green[pa], mb, lvl_green[pb], bright);
		d.blue = scale_level(ma, lvl_blue[pa], mb, lvl_blue[pb], bright);
		return d;
	endfunction

	// word source
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (advance_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < 15)) begin
				in_valid <= 1'b1;
				advance <= advance_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= idle_on ? ($urandom_range(0, 99) >= 15) : 1'b1;
	end

	// prediction and checking
	always @(posedge clk) begin
		duty_set_t want;
		cycle_cnt++;
		in_taken <= in_valid && in_ready;
		if (arst_n && cfg_valid && cfg_ready)
			bright_model = max_brightness;
		if (arst_n && in_valid && in_ready) begin
			fade_pos_model = (fade_pos_model + int'(advance)) % CYCLE_LEN;
			duty_q.push_back(fade_duties(fade_pos_model, int'(bright_model)));
		end
		if (arst_n && out_valid && out_ready) begin
			if (duty_q.size() == 0) begin
				$error("unexpected output word: red %0d green %0d blue %0d",
					red_duty, green_duty, blue_duty);
				err_count++;
			end else begin
				want = duty_q.pop_front();
				if (red_duty !== want.red) begin
					$error("red_duty expected %0d actual %0d", want.red, red_duty);
					err_count++;
				end
				if (green_duty !== want.green) begin
					$error("green_duty expected %0d actual %0d", want.green, green_duty);
					err_count++;
				end
				if (blue_duty !== want.blue) begin
					$error("blue_duty expected %0d actual %0d", want.blue, blue_duty);
					err_count++;
				end
			end
		end
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("rgb_palette_fade_interpolator verification failed");
			$finish;
		end
	end

	task automatic wait_drained();
		do
			@(posedge clk);
		while (advance_q.size() != 0 || in_valid || out_valid || duty_q.size() != 0);
	endtask

	task automatic write_brightness(input logic [rpf_pkg::DUTY_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		max_brightness <= value;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_words(input logic [15:0] pattern, input int count);
		for (int i = 0; i < count; i++)
			advance_q.push_back(pattern[i]);
	endtask

	initial begin
		logic [rpf_pkg::DUTY_W-1:0] level;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset brightness: hold, then step forward; then short runs at brightness 0, 1 and 1023
		queue_words(16'b0101_1100, 8);
		wait_drained();
		write_brightness(10'd0);
		queue_words(16'b101, 3);
		wait_drained();
		write_brightness(10'd1);
		queue_words(16'b011, 3);
		wait_drained();
		write_brightness(10'd1023);
		queue_words(16'b1101, 4);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: level = 10'd1023;
				1: level = 10'd0;
				2: level = 10'd1;
				default: level = rpf_pkg::DUTY_W'($urandom_range(0, 1023));
			endcase
			idle_on = (ph != 3);
			write_brightness(level);
			for (int i = 0; i < 100; i++)
				advance_q.push_back($urandom_range(0, 99) < 80);
			wait_drained();
		end
		idle_on = 1'b1;

		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("rgb_palette_fade_interpolator verification clean");
		else
			$display("rgb_palette_fade_interpolator verification failed");
		$finish;
	end

endmodule
